/* hw/rtl/bmvg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bmvg_pkg: shared types and constants of the battery median voltage gauge
// Holds field widths, register indexes, the charge curve and the structs
// that travel between the front, queue, divider and back.
// ---------------------------------------------------------------------------
package bmvg_pkg;

   localparam int PIN_W     = 12;
   localparam int CSR_W     = 16;
   localparam int MV_W      = 16;
   localparam int PCT_W     = 7;

   // register indexes of the configuration port
   localparam logic CSR_DIVIDER_NUMERATOR   = 1'b0;
   localparam logic CSR_DIVIDER_DENOMINATOR = 1'b1;

   localparam logic [CSR_W-1:0] NUMERATOR_RESET   = 16'd2;
   localparam logic [CSR_W-1:0] DENOMINATOR_RESET = 16'd1;

   // plausible battery window
   localparam logic [MV_W-1:0] PLAUSIBLE_MIN_MV = 16'd2500;
   localparam logic [MV_W-1:0] PLAUSIBLE_MAX_MV = 16'd4400;

   // charge curve: millivolts and percent at each knee
   localparam int CURVE_POINTS = 6;
   localparam int SEG_W        = 3;
   localparam logic [MV_W-1:0] CURVE_MV [CURVE_POINTS] =
      '{16'd3300, 16'd3400, 16'd3550, 16'd3700, 16'd3870, 16'd4200};
   localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_POINTS] =
      '{7'd0, 7'd5, 7'd25, 7'd50, 7'd75, 7'd100};

   // shared divider: dividend width, two quotient bits per cycle
   localparam int DIV_W       = 28;
   localparam int PAIRS_W     = 4;
   localparam logic [PAIRS_W-1:0] SCALE_PAIRS = 4'd14;
   localparam logic [PAIRS_W-1:0] PCT_PAIRS   = 4'd7;
   localparam int PCT_NUM_W   = 14;
   localparam int OFF_W       = 9;
   localparam int SPAN_PCT_W  = 5;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [CSR_W-1:0] numerator;
      logic [CSR_W-1:0] denominator;
   } cfg_type;

   typedef struct packed {
      logic             valid;
      logic [PIN_W-1:0] median;
   } median_word_type;

   typedef struct packed {
      logic               start;
      logic [DIV_W-1:0]   dividend;
      logic [CSR_W-1:0]   divisor;
      logic [PAIRS_W-1:0] pairs;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

/* hw/rtl/bmvg_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bmvg_req_if: sample channel
// Carries one ADC reading and its read status per word.
// ---------------------------------------------------------------------------
interface bmvg_req_if;
   logic                          valid;
   logic                          ready;
   logic [bmvg_pkg::PIN_W-1:0]    pin_millivolts;
   logic                          read_ok;

   modport source (output valid, output pin_millivolts, output read_ok, input ready);
   modport sink   (input valid, input pin_millivolts, input read_ok, output ready);
endinterface
`default_nettype wire

/* hw/rtl/bmvg_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bmvg_rsp_if: result channel
// Carries the battery voltage and charge estimate of one sample group.
// ---------------------------------------------------------------------------
interface bmvg_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bmvg_pkg::MV_W-1:0]     battery_millivolts;
   logic [bmvg_pkg::PCT_W-1:0]    charge_percent;
   logic                          percent_available;

   modport source (output valid, output battery_millivolts, output charge_percent,
                   output percent_available, input ready);
   modport sink   (input valid, input battery_millivolts, input charge_percent,
                   input percent_available, output ready);
endinterface
`default_nettype wire

/* hw/rtl/bmvg_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bmvg_front: sample collection and sorted insertion
// Keeps the current group in ascending order, inserting each reading as it
// is accepted, and pushes the median when the group completes.
// ---------------------------------------------------------------------------
module bmvg_front #(
   parameter int SAMPLES_PER_READING = 5
) (
   input  wire                          clock,
   input  wire                          reset,
   bmvg_req_if.sink                     req_port,
   input  wire                          queue_full,
   output bmvg_pkg::median_word_type    push
);

   localparam int N     = SAMPLES_PER_READING;
   localparam int CNT_W = $clog2(N + 1);

   logic [bmvg_pkg::PIN_W-1:0] sort_ff [N];
   logic [bmvg_pkg::PIN_W-1:0] sort_in [N];
   logic [CNT_W-1:0]           count_ff;
   logic [CNT_W-1:0]           count_in;
   logic [N-1:0]               above;
   logic [N-1:0]               prev_above;
   logic                       accept;
   logic                       last_sample;

   assign req_port.ready = !queue_full;
   assign accept         = req_port.valid && !queue_full;
   assign last_sample    = (count_ff == CNT_W'(N - 1));

   // mark held entries above the new reading
   always_comb begin
      for (int i = 0; i < N; i++) begin
         above[i] = (CNT_W'(i) < count_ff) && (sort_ff[i] > req_port.pin_millivolts);
      end
      prev_above[0] = 1'b0;
      for (int i = 1; i < N; i++) begin
         prev_above[i] = above[i-1];
      end
   end

   // shift larger entries up one place and drop the reading into the gap
   always_comb begin
      for (int i = 0; i < N; i++) begin
         if ((CNT_W'(i) < count_ff) && !above[i]) begin
            sort_in[i] = sort_ff[i];
         end else if (!prev_above[i]) begin
            sort_in[i] = req_port.pin_millivolts;
         end else begin
            sort_in[i] = sort_ff[(i == 0) ? 0 : i - 1];
         end
      end
   end

   // advance or drop the group count
   always_comb begin
      count_in = count_ff;
      if (accept) begin
         if (!req_port.read_ok || last_sample) begin
            count_in = '0;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // hold sorted group
   always_ff @(posedge clock) begin
      if (accept && req_port.read_ok) begin
         for (int i = 0; i < N; i++) begin
            sort_ff[i] <= sort_in[i];
         end
      end
   end

   assign push.valid  = accept && req_port.read_ok && last_sample;
   assign push.median = sort_in[N/2];

   // group count stays below the group size
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff < CNT_W'(N))
      else $error("group count out of range");

endmodule
`default_nettype wire

/* hw/rtl/bmvg_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bmvg_queue: median queue
// Two-entry queue that lets the front and the back stall independently.
// ---------------------------------------------------------------------------
module bmvg_queue (
   input  wire                          clock,
   input  wire                          reset,
   input  bmvg_pkg::median_word_type    push,
   input  wire                          pop,
   output logic                         full,
   output bmvg_pkg::median_word_type    head
);

   localparam int PTR_W = $clog2(bmvg_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(bmvg_pkg::QUEUE_DEPTH + 1);

   logic [bmvg_pkg::PIN_W-1:0] entry_ff [bmvg_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]           wr_ptr_ff;
   logic [PTR_W-1:0]           rd_ptr_ff;
   logic [CNT_W-1:0]           count_ff;
   logic [CNT_W-1:0]           count_in;
   logic                       do_pop;

   assign full        = (count_ff == CNT_W'(bmvg_pkg::QUEUE_DEPTH));
   assign head.valid  = (count_ff != '0);
   assign head.median = entry_ff[rd_ptr_ff];
   assign do_pop      = pop && head.valid;

   always_comb begin
      count_in = count_ff;
      if (push.valid && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push.valid && do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push.valid) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   // hold entries
   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.median;
      end
   end

   // the front never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push.valid)
      else $error("push into full queue");

endmodule
`default_nettype wire

/* hw/rtl/bmvg_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bmvg_div: shared iterative divider
// Restoring division, two quotient bits per cycle. The dividend arrives
// left-aligned so that the given number of bit pairs covers it.
// ---------------------------------------------------------------------------
module bmvg_div (
   input  wire                      clock,
   input  wire                      reset,
   input  bmvg_pkg::div_req_type    req,
   output bmvg_pkg::div_rsp_type    rsp
);

   localparam int DW = bmvg_pkg::DIV_W;
   localparam int RW = bmvg_pkg::CSR_W;

   logic                          busy_ff;
   logic                          done_ff;
   logic [bmvg_pkg::PAIRS_W-1:0]  pairs_ff;
   logic [DW-1:0]                 dvd_ff;
   logic [DW-1:0]                 quo_ff;
   logic [RW-1:0]                 rem_ff;
   logic [RW-1:0]                 divisor_ff;
   logic [RW:0]                   step_hi;
   logic [RW:0]                   step_lo;

   // one restoring step: returns {quotient bit, remainder}
   function automatic logic [RW:0] div_step(input logic [RW-1:0] rem,
                                            input logic          next_bit,
                                            input logic [RW-1:0] divisor);
      logic [RW:0] trial;
      logic [RW:0] diff;
      trial = {rem, next_bit};
      diff  = trial - {1'b0, divisor};
      if (trial >= {1'b0, divisor}) begin
         div_step = {1'b1, diff[RW-1:0]};
      end else begin
         div_step = {1'b0, rem[RW-2:0], next_bit};
      end
   endfunction

   assign step_hi = div_step(rem_ff, dvd_ff[DW-1], divisor_ff);
   assign step_lo = div_step(step_hi[RW-1:0], dvd_ff[DW-2], divisor_ff);

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (pairs_ff == bmvg_pkg::PAIRS_W'(1))) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (req.start) begin
         pairs_ff   <= req.pairs;
         dvd_ff     <= req.dividend;
         divisor_ff <= req.divisor;
         rem_ff     <= '0;
         quo_ff     <= '0;
      end else if (busy_ff) begin
         pairs_ff <= pairs_ff - bmvg_pkg::PAIRS_W'(1);
         dvd_ff   <= {dvd_ff[DW-3:0], 2'b00};
         rem_ff   <= step_lo[RW-1:0];
         quo_ff   <= {quo_ff[DW-3:0], step_hi[RW], step_lo[RW]};
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule
`default_nettype wire

/* hw/rtl/bmvg_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bmvg_back: scaling and charge estimate
// Pops one median, scales it by the divider ratio with rounding and
// saturation, interpolates the charge curve and registers the result word.
// ---------------------------------------------------------------------------
module bmvg_back (
   input  wire                          clock,
   input  wire                          reset,
   input  bmvg_pkg::cfg_type            cfg,
   input  bmvg_pkg::median_word_type    head,
   output logic                         pop,
   bmvg_rsp_if.source                   rsp_port
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_MUL   = 8'b0000_0010,
      ST_ROUND = 8'b0000_0100,
      ST_DIV   = 8'b0000_1000,
      ST_PCT   = 8'b0001_0000,
      ST_PDIV  = 8'b0010_0000,
      ST_DONE  = 8'b0100_0000,
      ST_SPARE = 8'b1000_0000
   } state_type;

   localparam int DW = bmvg_pkg::DIV_W;

   state_type                    state_ff;
   state_type                    state_in;
   logic [bmvg_pkg::PIN_W-1:0]   median_ff;
   logic [DW-1:0]                prod_ff;
   logic [bmvg_pkg::MV_W-1:0]    mv_ff;
   logic [bmvg_pkg::PCT_W-1:0]   pct_ff;
   logic                         avail_ff;
   logic [bmvg_pkg::PCT_W-1:0]   base_ff;
   logic                         rsp_valid_ff;
   logic [bmvg_pkg::MV_W-1:0]    rsp_mv_ff;
   logic [bmvg_pkg::PCT_W-1:0]   rsp_pct_ff;
   logic                         rsp_avail_ff;

   logic [bmvg_pkg::CSR_W-1:0]   den_eff;
   logic [DW-1:0]                rounded;
   logic [bmvg_pkg::MV_W-1:0]    mv_sat;
   logic                         avail;
   logic [bmvg_pkg::SEG_W-1:0]   seg;
   logic                         above_top;
   logic [bmvg_pkg::MV_W-1:0]    off_wide;
   logic [bmvg_pkg::MV_W-1:0]    vspan_wide;
   logic [bmvg_pkg::PCT_W-1:0]   pspan_wide;
   logic [bmvg_pkg::PCT_NUM_W-1:0] pct_num;
   logic                         load_out;
   bmvg_pkg::div_req_type        div_req;
   bmvg_pkg::div_rsp_type        div_rsp;

   bmvg_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // scale: a zero denominator acts as one
   assign den_eff = (cfg.denominator == '0) ? bmvg_pkg::CSR_W'(1) : cfg.denominator;
   assign rounded = prod_ff + DW'(den_eff >> 1);
   assign mv_sat  = (div_rsp.quotient[DW-1:bmvg_pkg::MV_W] != '0) ? '1
                                                  : div_rsp.quotient[bmvg_pkg::MV_W-1:0];

   // pick the curve segment whose upper knee first reaches the voltage
   always_comb begin
      seg       = bmvg_pkg::SEG_W'(1);
      above_top = 1'b1;
      for (int k = bmvg_pkg::CURVE_POINTS - 1; k >= 1; k--) begin
         if (mv_ff <= bmvg_pkg::CURVE_MV[k]) begin
            seg       = bmvg_pkg::SEG_W'(k);
            above_top = 1'b0;
         end
      end
      off_wide   = mv_ff - bmvg_pkg::CURVE_MV[seg - bmvg_pkg::SEG_W'(1)];
      vspan_wide = bmvg_pkg::CURVE_MV[seg] - bmvg_pkg::CURVE_MV[seg - bmvg_pkg::SEG_W'(1)];
      pspan_wide = bmvg_pkg::CURVE_PCT[seg] - bmvg_pkg::CURVE_PCT[seg - bmvg_pkg::SEG_W'(1)];
      pct_num    = bmvg_pkg::PCT_NUM_W'(off_wide[bmvg_pkg::OFF_W-1:0]
                                        * pspan_wide[bmvg_pkg::SPAN_PCT_W-1:0])
                 + bmvg_pkg::PCT_NUM_W'(vspan_wide >> 1);
   end

   assign avail = (mv_ff >= bmvg_pkg::PLAUSIBLE_MIN_MV) &&
                  (mv_ff <= bmvg_pkg::PLAUSIBLE_MAX_MV);

   assign load_out = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_port.ready);
   assign pop      = (state_ff == ST_IDLE) && head.valid;

   // start the divider for the scale and for the percent
   always_comb begin
      div_req = '0;
      if (state_ff == ST_ROUND) begin
         div_req.start    = 1'b1;
         div_req.dividend = rounded;
         div_req.divisor  = den_eff;
         div_req.pairs    = bmvg_pkg::SCALE_PAIRS;
      end else if ((state_ff == ST_PCT) && avail &&
                   (mv_ff > bmvg_pkg::CURVE_MV[0]) && !above_top) begin
         div_req.start    = 1'b1;
         div_req.dividend = {pct_num, (DW - bmvg_pkg::PCT_NUM_W)'(0)};
         div_req.divisor  = vspan_wide;
         div_req.pairs    = bmvg_pkg::PCT_PAIRS;
      end
   end

   // sequence one median through the datapath
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:   state_in = ST_ROUND;
         ST_ROUND: state_in = ST_DIV;
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_PCT;
            end
         end
         ST_PCT: begin
            if (div_req.start) begin
               state_in = ST_PDIV;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_PDIV: begin
            if (div_rsp.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (pop) begin
         median_ff <= head.median;
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= DW'(median_ff * cfg.numerator);
      end
      if ((state_ff == ST_DIV) && div_rsp.done) begin
         mv_ff <= mv_sat;
      end
      if (state_ff == ST_PCT) begin
         avail_ff <= avail;
         base_ff  <= bmvg_pkg::CURVE_PCT[seg - bmvg_pkg::SEG_W'(1)];
         if (!avail || (mv_ff <= bmvg_pkg::CURVE_MV[0])) begin
            pct_ff <= bmvg_pkg::CURVE_PCT[0];
         end else begin
            pct_ff <= bmvg_pkg::CURVE_PCT[bmvg_pkg::CURVE_POINTS-1];
         end
      end
      if ((state_ff == ST_PDIV) && div_rsp.done) begin
         pct_ff <= base_ff + div_rsp.quotient[bmvg_pkg::PCT_W-1:0];
      end
   end

   // hold the result word until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_mv_ff    <= mv_ff;
         rsp_pct_ff   <= pct_ff;
         rsp_avail_ff <= avail_ff;
      end
   end

   assign rsp_port.valid              = rsp_valid_ff;
   assign rsp_port.battery_millivolts = rsp_mv_ff;
   assign rsp_port.charge_percent     = rsp_pct_ff;
   assign rsp_port.percent_available  = rsp_avail_ff;

   // a voltage outside the window carries no percent
   a_pct_unavail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_avail_ff) |-> (rsp_pct_ff == '0))
      else $error("percent set while unavailable");

   // percent never exceeds the top of the curve
   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_pct_ff <= bmvg_pkg::CURVE_PCT[bmvg_pkg::CURVE_POINTS-1]))
      else $error("percent above full charge");

   // the divider only reports while a division is awaited
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> ((state_ff == ST_DIV) || (state_ff == ST_PDIV)))
      else $error("divider done out of sequence");

endmodule
`default_nettype wire

/* hw/rtl/battery_median_voltage_gauge.sv */
// Result path: the median of a completed group passes the median queue, the scale
//   division and, when the voltage lies between the outer knees, the percent division.
// Throughput: one sample word per cycle while the two-entry median queue has room;
//   the back handles one median at a time and pops the next once its result word is loaded.
// Reset: synchronous, active high; clears the group count, queue and control,
//   and sets the divider ratio to 2/1. Sample storage is not cleared.
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// battery_median_voltage_gauge: median-filtered battery voltage gauge
// Collects ADC readings in groups, takes the median, scales it by the
// divider ratio and interpolates a charge percent on a fixed curve.
// ---------------------------------------------------------------------------
module battery_median_voltage_gauge #(
   parameter int SAMPLES_PER_READING = 5
) (
   input  wire                          clock,
   input  wire                          reset,
   bmvg_req_if.sink                     req_port,
   bmvg_rsp_if.source                   rsp_port,
   input  wire                          csr_write_enable,
   input  wire                          csr_index,
   input  wire [bmvg_pkg::CSR_W-1:0]    csr_write_data
);

   bmvg_pkg::cfg_type            cfg_ff;
   bmvg_pkg::median_word_type    push;
   bmvg_pkg::median_word_type    head;
   logic                         queue_full;
   logic                         pop;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.numerator   <= bmvg_pkg::NUMERATOR_RESET;
         cfg_ff.denominator <= bmvg_pkg::DENOMINATOR_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            bmvg_pkg::CSR_DIVIDER_NUMERATOR:   cfg_ff.numerator   <= csr_write_data;
            bmvg_pkg::CSR_DIVIDER_DENOMINATOR: cfg_ff.denominator <= csr_write_data;
            default: ;
         endcase
      end
   end

   bmvg_front #(
      .SAMPLES_PER_READING (SAMPLES_PER_READING)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_port   (req_port),
      .queue_full (queue_full),
      .push       (push)
   );

   bmvg_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .head  (head)
   );

   bmvg_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .head     (head),
      .pop      (pop),
      .rsp_port (rsp_port)
   );

endmodule
`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the battery median voltage gauge
// Feeds ADC reading words through the sample channel and predicts each
// group's median, scaled voltage and charge percent. Every result word is
// checked against the oldest prediction. Both channels idle at random, and
// one long result stall backs the block up.
// ---------------------------------------------------------------------------
module tb_top;

   localparam int GROUP_SIZE    = 5;
   localparam int SETTLE_CYCLES = 64;
   localparam int HOLD_CYCLES   = 400;
   localparam int TAIL_OPS      = 200;
   localparam int TIMEOUT_NS    = 2_000_000;
   localparam int KNEES         = 6;

   localparam int unsigned KNEE_MV  [KNEES] = '{3300, 3400, 3550, 3700, 3870, 4200};
   localparam int unsigned KNEE_PCT [KNEES] = '{0, 5, 25, 50, 75, 100};

   typedef enum logic [1:0] {OP_WORD, OP_CSR, OP_DRAIN, OP_HOLD} stim_kind_type;

   typedef struct {
      stim_kind_type              kind;
      logic [bmvg_pkg::PIN_W-1:0] pin;
      logic                       ok;
      logic                       csr_idx;
      logic [bmvg_pkg::CSR_W-1:0] csr_data;
   } stim_op_type;

   typedef struct {
      logic [bmvg_pkg::MV_W-1:0]  mv;
      logic [bmvg_pkg::PCT_W-1:0] pct;
      logic                       avail;
   } gauge_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                       csr_write_enable;
   logic                       csr_index;
   logic [bmvg_pkg::CSR_W-1:0] csr_write_data;

   bmvg_req_if req_bus ();
   bmvg_rsp_if rsp_bus ();

   battery_median_voltage_gauge #(
      .SAMPLES_PER_READING(GROUP_SIZE)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_port         (req_bus),
      .rsp_port         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // pending stimulus and predicted results
   stim_op_type      stim_q [$];
   gauge_result_type gauge_results_due [$];

   // predictor state
   logic [bmvg_pkg::PIN_W-1:0] window_pins [GROUP_SIZE];
   int                         window_fill;
   logic [bmvg_pkg::CSR_W-1:0] gauge_numerator;
   logic [bmvg_pkg::CSR_W-1:0] gauge_denominator;

   int   fault_count;
   int   req_gap;
   int   rsp_gap;
   int   drain_wait;
   int   hold_left;
   logic hold_request;
   logic quiet_stretch;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ----------------------------------------------------------------------
   // prediction
   // ----------------------------------------------------------------------
   function automatic logic [bmvg_pkg::PIN_W-1:0] window_median();
      logic [bmvg_pkg::PIN_W-1:0] work [GROUP_SIZE];
      logic [bmvg_pkg::PIN_W-1:0] v;
      int                         j;
      for (int i = 0; i < GROUP_SIZE; i++) work[i] = window_pins[i];
      // insertion sort, ascending
      for (int i = 1; i < GROUP_SIZE; i++) begin
         v = work[i];
         j = i;
         while (j > 0 && work[j-1] > v) begin
            work[j] = work[j-1];
            j--;
         end
         work[j] = v;
      end
      return work[GROUP_SIZE/2];
   endfunction

   function automatic logic [bmvg_pkg::PCT_W-1:0] charge_from_mv(
      input logic [bmvg_pkg::MV_W-1:0] mv);
      int unsigned off;
      int unsigned vspan;
      int unsigned pspan;
      if (mv <= KNEE_MV[0]) return KNEE_PCT[0][bmvg_pkg::PCT_W-1:0];
      for (int k = 1; k < KNEES; k++) begin
         if (mv <= KNEE_MV[k]) begin
            off   = mv - KNEE_MV[k-1];
            vspan = KNEE_MV[k] - KNEE_MV[k-1];
            pspan = KNEE_PCT[k] - KNEE_PCT[k-1];
            return bmvg_pkg::PCT_W'(KNEE_PCT[k-1] + (off * pspan + vspan / 2) / vspan);
         end
      end
      return KNEE_PCT[KNEES-1][bmvg_pkg::PCT_W-1:0];
   endfunction

   // take one accepted reading word; queue a result when a group closes
   function automatic void absorb_sample(input logic [bmvg_pkg::PIN_W-1:0] pin,
                                         input logic ok);
      gauge_result_type           r;
      logic [bmvg_pkg::PIN_W-1:0] med;
      longint unsigned            den;
      longint unsigned            scaled;
      if (!ok) begin
         window_fill = 0;
         return;
      end
      if (window_fill >= GROUP_SIZE) window_fill = 0;
      window_pins[window_fill] = pin;
      window_fill++;
      if (window_fill < GROUP_SIZE) return;
      window_fill = 0;
      med    = window_median();
      den    = (gauge_denominator == '0) ? 1 : gauge_denominator;
      scaled = (longint'(med) * gauge_numerator + den / 2) / den;
      r.mv    = (scaled > 65535) ? 16'hFFFF : bmvg_pkg::MV_W'(scaled);
      r.avail = (r.mv >= bmvg_pkg::PLAUSIBLE_MIN_MV && r.mv <= bmvg_pkg::PLAUSIBLE_MAX_MV);
      r.pct   = r.avail ? charge_from_mv(r.mv) : '0;
      gauge_results_due.push_back(r);
   endfunction

   // ----------------------------------------------------------------------
   // stimulus building
   // ----------------------------------------------------------------------
   function automatic void push_word(input int pin, input logic ok);
      stim_op_type op;
      op.kind     = OP_WORD;
      op.pin      = pin[bmvg_pkg::PIN_W-1:0];
      op.ok       = ok;
      op.csr_idx  = bmvg_pkg::CSR_DIVIDER_NUMERATOR;
      op.csr_data = '0;
      stim_q.push_back(op);
   endfunction

   function automatic void push_marker(input stim_kind_type kind);
      stim_op_type op;
      op.kind     = kind;
      op.pin      = '0;
      op.ok       = 1'b0;
      op.csr_idx  = bmvg_pkg::CSR_DIVIDER_NUMERATOR;
      op.csr_data = '0;
      stim_q.push_back(op);
   endfunction

   // settle, then write both divider registers
   function automatic void push_ratio(input int num, input int den);
      stim_op_type op;
      push_marker(OP_DRAIN);
      op.kind     = OP_CSR;
      op.pin      = '0;
      op.ok       = 1'b0;
      op.csr_idx  = bmvg_pkg::CSR_DIVIDER_NUMERATOR;
      op.csr_data = num[bmvg_pkg::CSR_W-1:0];
      stim_q.push_back(op);
      op.csr_idx  = bmvg_pkg::CSR_DIVIDER_DENOMINATOR;
      op.csr_data = den[bmvg_pkg::CSR_W-1:0];
      stim_q.push_back(op);
   endfunction

   // pin value whose scaled result lands near a knee or a window edge, or at random
   function automatic int pick_target(input int num, input int den);
      int knees [10] = '{2500, 3000, 3300, 3400, 3550, 3700, 3870, 4200, 4300, 4400};
      int mv;
      int d;
      longint pin;
      d = (den == 0) ? 1 : den;
      if (num == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 4095);
      if ($urandom_range(0, 9) < 6)
         mv = knees[$urandom_range(0, 9)] + int'($urandom_range(0, 4)) - 2;
      else
         mv = $urandom_range(2300, 4600);
      pin = (longint'(mv) * d + num / 2) / num;
      return (pin > 4095) ? 4095 : int'(pin);
   endfunction

   function automatic void push_group(input int target);
      int pick;
      int pin;
      for (int n = 0; n < GROUP_SIZE; n++) begin
         pick = $urandom_range(0, 19);
         if (pick < 5)       pin = target;
         else if (pick < 17) pin = target + int'($urandom_range(0, 16)) - 8;
         else                pin = $urandom_range(0, 4095);
         if (pin < 0)    pin = 0;
         if (pin > 4095) pin = 4095;
         push_word(pin, 1'b1);
      end
   endfunction

   // a partial group cut short by a failed read
   function automatic void push_broken(input int target);
      int count;
      count = $urandom_range(1, GROUP_SIZE - 1);
      for (int n = 0; n < count; n++) push_word(target + int'($urandom_range(0, 6)) - 3, 1'b1);
      push_word($urandom_range(0, 4095), 1'b0);
   endfunction

   function automatic bit idling_allowed();
      return !quiet_stretch && stim_q.size() > TAIL_OPS;
   endfunction

   function automatic void report_fault(input string what, input gauge_result_type want,
                                        input gauge_result_type got);
      fault_count++;
      if (fault_count <= 10)
         $display("%0t %s: expected mv=%0d pct=%0d avail=%0d, got mv=%0d pct=%0d avail=%0d",
                  $realtime, what, want.mv, want.pct, want.avail, got.mv, got.pct, got.avail);
   endfunction

   // ----------------------------------------------------------------------
   // driver: sample words, register writes, settle pauses
   // ----------------------------------------------------------------------
   always @(posedge clock) begin : sample_driver
      stim_op_type op;
      logic        next_valid;
      logic        next_we;
      logic        next_hold;
      if (reset) begin
         req_bus.valid    <= 1'b0;
         csr_write_enable <= 1'b0;
         hold_request     <= 1'b0;
         req_gap    = 0;
         drain_wait = 0;
      end else begin
         next_valid = req_bus.valid;
         next_we    = 1'b0;
         next_hold  = 1'b0;
         // retire the accepted word
         if (req_bus.valid && req_bus.ready) begin
            absorb_sample(req_bus.pin_millivolts, req_bus.read_ok);
            op = stim_q.pop_front();
            next_valid = 1'b0;
            if (idling_allowed() && $urandom_range(0, 3) == 0) req_gap = $urandom_range(1, 7);
            if ($urandom_range(0, 63) == 0) quiet_stretch <= !quiet_stretch;
         end
         // pick up the next operation once nothing is in flight
         if (!next_valid && stim_q.size() != 0) begin
            op = stim_q[0];
            case (op.kind)
               OP_WORD: begin
                  if (req_gap > 0) begin
                     req_gap--;
                  end else begin
                     next_valid = 1'b1;
                     req_bus.pin_millivolts <= op.pin;
                     req_bus.read_ok        <= op.ok;
                  end
               end
               OP_CSR: begin
                  next_we = 1'b1;
                  csr_index      <= op.csr_idx;
                  csr_write_data <= op.csr_data;
                  if (op.csr_idx == bmvg_pkg::CSR_DIVIDER_NUMERATOR)
                     gauge_numerator = op.csr_data;
                  else
                     gauge_denominator = op.csr_data;
                  op = stim_q.pop_front();
               end
               OP_DRAIN: begin
                  if (gauge_results_due.size() == 0) drain_wait++;
                  else                               drain_wait = 0;
                  if (drain_wait >= SETTLE_CYCLES) begin
                     drain_wait = 0;
                     op = stim_q.pop_front();
                  end
               end
               OP_HOLD: begin
                  next_hold = 1'b1;
                  op = stim_q.pop_front();
               end
               default: op = stim_q.pop_front();
            endcase
         end
         req_bus.valid    <= next_valid;
         csr_write_enable <= next_we;
         hold_request     <= next_hold;
      end
   end

   // ----------------------------------------------------------------------
   // long result stall, counted here
   // ----------------------------------------------------------------------
   always @(posedge clock) begin : backpressure_hold
      if (reset) begin
         hold_left <= 0;
      end else if (hold_request) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // ----------------------------------------------------------------------
   // monitor: check result words, throttle ready
   // ----------------------------------------------------------------------
   always @(posedge clock) begin : result_monitor
      gauge_result_type want;
      gauge_result_type got;
      logic             next_ready;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_gap = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.mv    = rsp_bus.battery_millivolts;
            got.pct   = rsp_bus.charge_percent;
            got.avail = rsp_bus.percent_available;
            if (gauge_results_due.size() == 0) begin
               want = '{mv: '0, pct: '0, avail: 1'b0};
               report_fault("unexpected result", want, got);
            end else begin
               want = gauge_results_due.pop_front();
               if (got.mv !== want.mv || got.pct !== want.pct || got.avail !== want.avail)
                  report_fault("result mismatch", want, got);
            end
         end
         if (hold_left != 0) begin
            next_ready = 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            next_ready = 1'b0;
         end else begin
            next_ready = 1'b1;
            if (idling_allowed() && $urandom_range(0, 4) == 0) rsp_gap = $urandom_range(1, 7);
         end
         rsp_bus.ready <= next_ready;
      end
   end

   // ----------------------------------------------------------------------
   // stimulus, reset and end of run
   // ----------------------------------------------------------------------
   initial begin : stimulus
      int ratio_num [12] = '{1, 2, 65535, 65535, 1, 0, 3, 11, 7, 0, 0, 2};
      int ratio_den [12] = '{1, 1, 65535, 1, 65535, 7, 0, 10, 4, 0, 0, 1};
      int groups;
      int num;
      int den;
      int target;
      int pick;

      req_bus.valid          = 1'b0;
      req_bus.pin_millivolts = '0;
      req_bus.read_ok        = 1'b0;
      rsp_bus.ready          = 1'b0;
      csr_write_enable       = 1'b0;
      csr_index              = bmvg_pkg::CSR_DIVIDER_NUMERATOR;
      csr_write_data         = '0;
      hold_request           = 1'b0;
      quiet_stretch          = 1'b0;
      fault_count            = 0;
      window_fill            = 0;
      gauge_numerator        = bmvg_pkg::NUMERATOR_RESET;
      gauge_denominator      = bmvg_pkg::DENOMINATOR_RESET;
      for (int i = 0; i < GROUP_SIZE; i++) window_pins[i] = '0;

      // directed, at the reset ratio of 2/1
      push_word(0, 1'b1);
      push_word(4095, 1'b1);
      push_word(1700, 1'b1);
      push_word(1800, 1'b1);
      push_word(1750, 1'b1);
      // failed read drops a partial group
      push_word(1650, 1'b1);
      push_word(1650, 1'b1);
      push_word(4095, 1'b0);
      // full scale lies above the window, zero sits below it
      for (int n = 0; n < GROUP_SIZE; n++) push_word(4095, 1'b1);
      for (int n = 0; n < GROUP_SIZE; n++) push_word(0, 1'b1);
      // above the top knee but inside the window
      push_word(1600, 1'b1);
      push_word(2150, 1'b1);
      push_word(2150, 1'b1);
      push_word(1600, 1'b1);
      push_word(2150, 1'b1);

      // random phases, each under its own divider ratio
      for (int phase = 0; phase < 12; phase++) begin
         num = ratio_num[phase];
         den = ratio_den[phase];
         if (phase == 9) begin
            den = $urandom_range(1, 65535);
            num = den + $urandom_range(0, den);
            if (num > 65535) num = 65535;
         end else if (phase == 10) begin
            num = $urandom_range(1, 65535);
            den = $urandom_range(1, 65535);
         end
         push_ratio(num, den);
         if (phase == 6) push_marker(OP_HOLD);
         groups = (num == 0) ? 5 : 26;
         for (int g = 0; g < groups; g++) begin
            target = pick_target(num, den);
            pick   = $urandom_range(0, 19);
            if (pick == 0)      push_broken(target);
            else if (pick == 1) push_word($urandom_range(0, 4095), 1'b0);
            else                push_group(target);
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (stim_q.size() != 0 || gauge_results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0 && gauge_results_due.size() == 0) begin
         $display("PASS battery_median_voltage_gauge");
      end else begin
         $display("FAIL battery_median_voltage_gauge");
      end
      $finish;
   end

   initial begin : watchdog
      #TIMEOUT_NS;
      $display("FAIL battery_median_voltage_gauge");
      $finish;
   end

endmodule

/* files.f */
hw/rtl/bmvg_pkg.sv
hw/rtl/bmvg_req_if.sv
hw/rtl/bmvg_rsp_if.sv
hw/rtl/bmvg_front.sv
hw/rtl/bmvg_queue.sv
hw/rtl/bmvg_div.sv
hw/rtl/bmvg_back.sv
hw/rtl/battery_median_voltage_gauge.sv
sim/tb_top.sv
